>>> hw/rtl/shpk_pkg.sv
// Shared types and constants for the shelf packer.
// Used by every module of the block; depends on nothing.
package shpk_pkg;

    localparam int COORD_W = 13;
    localparam logic [COORD_W-1:0] ATLAS_RESET = 13'd4096;

    typedef enum logic [1:0] {
        ST_PLACED = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_TABLE  = 2'd3
    } status_t;

    // One shelf entry as held in the shelf memory.
    typedef struct packed {
        logic [COORD_W-1:0] next_x;
        logic [COORD_W-1:0] top_y;
        logic [COORD_W-1:0] height;
    } shelf_t;

    // One placement result.
    typedef struct packed {
        status_t            status;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
    } res_t;

endpackage

>>> hw/rtl/shpk_shelf_mem.sv
// Shelf table memory: one write port, one read port, registered read data.
// Depends on shpk_pkg for the entry layout.
module shpk_shelf_mem #(
    parameter int DEPTH = 64
) (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output shpk_pkg::shelf_t          rd_data,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  shpk_pkg::shelf_t          wr_data
);
    import shpk_pkg::*;

    shelf_t mem [DEPTH];
    shelf_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/shpk_ctrl.sv
// Scan sequencer: first-fit search over the shelf memory, shelf opening
// and write-back of the chosen shelf. Depends on shpk_pkg.
module shpk_ctrl #(
    parameter int MAX_SHELVES = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 new_atlas,
    input  logic [shpk_pkg::COORD_W-1:0]         tile_width,
    input  logic [shpk_pkg::COORD_W-1:0]         tile_height,
    input  logic [shpk_pkg::COORD_W-1:0]         size,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output shpk_pkg::res_t                       res,
    output logic                                 rd_en,
    output logic [$clog2(MAX_SHELVES)-1:0]       rd_addr,
    input  shpk_pkg::shelf_t                     rd_data,
    output logic                                 wr_en,
    output logic [$clog2(MAX_SHELVES)-1:0]       wr_addr,
    output shpk_pkg::shelf_t                     wr_data
);
    import shpk_pkg::*;

    localparam int IDX_W = $clog2(MAX_SHELVES);
    localparam int CNT_W = $clog2(MAX_SHELVES + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_OPEN  = 5'b00100,
        S_WRITE = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               e0_valid_reg, e0_valid_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]   chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0]   hit_reg, hit_next;
    logic [COORD_W-1:0] tw_reg, tw_next;
    logic [COORD_W-1:0] th_reg, th_next;
    logic [COORD_W-1:0] px_reg, px_next;
    logic [COORD_W-1:0] py_reg, py_next;
    logic [COORD_W-1:0] sh_reg, sh_next;
    logic [COORD_W:0]   ny_reg, ny_next;
    res_t               res_reg, res_next;

    shelf_t             entry;
    logic               fit;
    logic               issue;
    logic [COORD_W:0]   nx_sum;
    logic [COORD_W-1:0] nx_sat;
    logic [COORD_W-1:0] h_max;
    logic               open_full;

    // Entry 0 reads as an empty shelf until written after a clear.
    always_comb
    begin
        if (chk_idx_reg == '0 && !e0_valid_reg)
        begin
            entry = '0;
        end
        else
        begin
            entry = rd_data;
        end
    end

    assign fit = ({1'b0, entry.next_x} + {1'b0, tw_reg} <= {1'b0, size})
              && ({1'b0, entry.top_y} + {1'b0, th_reg} <= {1'b0, size})
              && (entry.height == '0 || th_reg <= entry.height);

    assign issue     = (state_reg == S_SCAN) && (rd_idx_reg < count_reg);
    assign nx_sum    = {1'b0, px_reg} + {1'b0, tw_reg};
    assign nx_sat    = (nx_sum > {1'b0, size}) ? size : nx_sum[COORD_W-1:0];
    assign h_max     = (sh_reg < th_reg) ? th_reg : sh_reg;
    assign open_full = ({1'b0, ny_reg} + {2'b0, th_reg}) > {2'b0, size};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        e0_valid_next  = e0_valid_reg;
        chk_valid_next = chk_valid_reg;
        rd_idx_next    = rd_idx_reg;
        chk_idx_next   = chk_idx_reg;
        hit_next       = hit_reg;
        tw_next        = tw_reg;
        th_next        = th_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        sh_next        = sh_reg;
        ny_next        = ny_reg;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_addr        = hit_reg[IDX_W-1:0];
        wr_data        = '{next_x: nx_sat, top_y: py_reg, height: h_max};

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    tw_next        = tile_width;
                    th_next        = tile_height;
                    rd_idx_next    = '0;
                    chk_valid_next = 1'b0;
                    if (new_atlas)
                    begin
                        count_next    = CNT_W'(1);
                        e0_valid_next = 1'b0;
                    end
                    if (tile_width == '0 || tile_height == '0)
                    begin
                        res_next   = '{status: ST_EMPTY, pos_x: '0, pos_y: '0};
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Reads go out one a cycle; each is checked in the cycle after it is issued.
                chk_valid_next = issue;
                chk_idx_next   = rd_idx_reg;
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (chk_valid_reg)
                begin
                    if (fit)
                    begin
                        hit_next       = chk_idx_reg;
                        px_next        = entry.next_x;
                        py_next        = entry.top_y;
                        sh_next        = entry.height;
                        chk_valid_next = 1'b0;
                        state_next     = S_WRITE;
                    end
                    else if (chk_idx_reg == count_reg - CNT_W'(1))
                    begin
                        ny_next        = {1'b0, entry.top_y} + {1'b0, entry.height};
                        chk_valid_next = 1'b0;
                        state_next     = S_OPEN;
                    end
                end
            end

            S_OPEN:
            begin
                if (open_full)
                begin
                    res_next   = '{status: ST_FULL, pos_x: '0, pos_y: '0};
                    state_next = S_RESP;
                end
                else if (count_reg == CNT_W'(MAX_SHELVES))
                begin
                    res_next   = '{status: ST_TABLE, pos_x: '0, pos_y: '0};
                    state_next = S_RESP;
                end
                else
                begin
                    hit_next   = count_reg;
                    px_next    = '0;
                    py_next    = ny_reg[COORD_W-1:0];
                    sh_next    = '0;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_WRITE;
                end
            end

            S_WRITE:
            begin
                wr_en = 1'b1;
                if (hit_reg == '0)
                begin
                    e0_valid_next = 1'b1;
                end
                res_next   = '{status: ST_PLACED, pos_x: px_reg, pos_y: py_reg};
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CNT_W'(1);
            e0_valid_reg  <= 1'b0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            e0_valid_reg  <= e0_valid_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= rd_idx_next;
        chk_idx_reg <= chk_idx_next;
        hit_reg     <= hit_next;
        tw_reg      <= tw_next;
        th_reg      <= th_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        sh_reg      <= sh_next;
        ny_reg      <= ny_next;
        res_reg     <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res       = res_reg;
    assign rd_en     = issue;
    assign rd_addr   = rd_idx_reg[IDX_W-1:0];

endmodule

>>> hw/rtl/shelf_packer_first_fit_core.sv
// Shelf packer, first-fit. One request at a time: an empty tile goes straight to its result;
// otherwise the shelves in use (up to MAX_SHELVES) are scanned with one shelf memory read
// per cycle until one fits, and if none fits a shelf is opened or the tile is refused.
// The result waits in an output register, so the next request is taken meanwhile.
// Reset: atlas size 4096, a single empty shelf, no result pending; no clearing pass.
// Holds the atlas size register and the output register; depends on shpk_pkg.
module shelf_packer_first_fit_core #(
    parameter int MAX_SHELVES = 64,
    parameter int MAX_ATLAS   = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [shpk_pkg::COORD_W-1:0]  cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          new_atlas,
    input  logic [shpk_pkg::COORD_W-1:0]  tile_width,
    input  logic [shpk_pkg::COORD_W-1:0]  tile_height,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [shpk_pkg::COORD_W-1:0]  pos_x,
    output logic [shpk_pkg::COORD_W-1:0]  pos_y
);
    import shpk_pkg::*;

    localparam int IDX_W = $clog2(MAX_SHELVES);

    logic [COORD_W-1:0] atlas_size_reg;
    logic [COORD_W-1:0] size;
    logic               out_valid_reg, out_valid_next;
    res_t               out_res_reg;
    logic               res_valid;
    logic               res_ready;
    res_t               res;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    shelf_t             rd_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    shelf_t             wr_data;

    // Clamp the programmed size to the largest atlas supported.
    assign size = ({2'b0, atlas_size_reg} > (COORD_W + 2)'(MAX_ATLAS))
                ? COORD_W'(MAX_ATLAS) : atlas_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atlas_size_reg <= ATLAS_RESET;
        end
        else if (cfg_wr_en)
        begin
            atlas_size_reg <= cfg_wr_data;
        end
    end

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    shpk_ctrl #(
        .MAX_SHELVES (MAX_SHELVES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .new_atlas   (new_atlas),
        .tile_width  (tile_width),
        .tile_height (tile_height),
        .size        (size),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    shpk_shelf_mem #(
        .DEPTH (MAX_SHELVES)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign out_valid = out_valid_reg;
    assign status    = out_res_reg.status;
    assign pos_x     = out_res_reg.pos_x;
    assign pos_y     = out_res_reg.pos_y;

    // One request in flight: acceptance drops ready for the next cycle.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in flight");

    // A handed-over result lands in the output register.
    a_res_loads: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> out_valid)
        else $error("result lost at output register");

    // A tile that is not placed reports the origin.
    a_unplaced_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_PLACED |-> pos_x == '0 && pos_y == '0)
        else $error("unplaced tile reports a position");

endmodule

>>> bench/tb.sv
// Testbench for shelf_packer_first_fit_core: tiles go in by valid/ready, and each
// placement is checked against a shelf table kept here. Depends on shpk_pkg and the core.
`timescale 1ns / 1ps

module tb;
    import shpk_pkg::*;

    localparam int SHELF_SLOTS   = 64;
    localparam int ATLAS_LIMIT   = 4096;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 1000000;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [COORD_W-1:0] cfg_wr_data = '0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic               new_atlas   = 1'b0;
    logic [COORD_W-1:0] tile_width  = '0;
    logic [COORD_W-1:0] tile_height = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic [1:0]         status;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;

    // Shelf table as the block should hold it
    logic [COORD_W-1:0] atlas_edge;
    logic [COORD_W-1:0] row_fill [SHELF_SLOTS];
    logic [COORD_W-1:0] row_top  [SHELF_SLOTS];
    logic [COORD_W-1:0] row_tall [SHELF_SLOTS];
    int                 rows_open;

    res_t placements_due[$];
    int   mismatches = 0;
    bit   idle_on    = 1'b0;
    bit   hold_req   = 1'b0;

    shelf_packer_first_fit_core #(
        .MAX_SHELVES (SHELF_SLOTS),
        .MAX_ATLAS   (ATLAS_LIMIT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .new_atlas   (new_atlas),
        .tile_width  (tile_width),
        .tile_height (tile_height),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .pos_x       (pos_x),
        .pos_y       (pos_y)
    );

    always #5 clk = ~clk;

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic void clear_rows();
        int i;
        for (i = 0; i < SHELF_SLOTS; i++)
        begin
            row_fill[i] = '0;
            row_top[i]  = '0;
            row_tall[i] = '0;
        end
        rows_open = 1;
    endfunction

    // First-fit placement of one tile against the local shelf table
    function automatic res_t place_tile(bit fresh, logic [COORD_W-1:0] w,
                                        logic [COORD_W-1:0] h);
        res_t r;
        int   lim, tw, th, n, i, hit, ny, nx, sx, sy, sh;
        bit   found;
        r.status = ST_EMPTY;
        r.pos_x  = '0;
        r.pos_y  = '0;
        lim = (atlas_edge > ATLAS_LIMIT) ? ATLAS_LIMIT : int'(atlas_edge);
        tw  = int'(w);
        th  = int'(h);
        if (fresh)
            clear_rows();
        if (tw == 0 || th == 0)
            return r;
        n = rows_open;
        if (n < 1)
            n = 1;
        if (n > SHELF_SLOTS)
            n = SHELF_SLOTS;
        found = 1'b0;
        hit   = 0;
        for (i = 0; i < n && !found; i++)
        begin
            sx = int'(row_fill[i]);
            sy = int'(row_top[i]);
            sh = int'(row_tall[i]);
            if (lim - sx >= tw && lim - sy >= th && (sh == 0 || th <= sh))
            begin
                hit   = i;
                found = 1'b1;
            end
        end
        if (!found)
        begin
            ny = int'(row_top[n-1]) + int'(row_tall[n-1]);
            if (ny + th > lim)
            begin
                r.status = ST_FULL;
                return r;
            end
            if (n >= SHELF_SLOTS)
            begin
                r.status = ST_TABLE;
                return r;
            end
            hit           = n;
            row_fill[hit] = '0;
            row_top[hit]  = ny[COORD_W-1:0];
            row_tall[hit] = '0;
            rows_open     = n + 1;
        end
        r.status = ST_PLACED;
        r.pos_x  = row_fill[hit];
        r.pos_y  = row_top[hit];
        nx = int'(row_fill[hit]) + tw;
        if (nx > lim)
            nx = lim;
        row_fill[hit] = nx[COORD_W-1:0];
        if (int'(row_tall[hit]) < th)
            row_tall[hit] = h;
        return r;
    endfunction

    // Offer one request and hold it until taken; valid stays high for the next one
    task automatic send_tile(bit fresh, int w, int h);
        int   gap;
        res_t due;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        new_atlas   <= fresh;
        tile_width  <= w[COORD_W-1:0];
        tile_height <= h[COORD_W-1:0];
        do @(posedge clk); while (in_ready !== 1'b1);
        due = place_tile(fresh, w[COORD_W-1:0], h[COORD_W-1:0]);
        placements_due = {placements_due, due};
    endtask

    // Drain every pending result, then write the register while the block is idle
    task automatic set_atlas_size(int v);
        in_valid <= 1'b0;
        while (placements_due.size() != 0) @(posedge clk);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[COORD_W-1:0];
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        atlas_edge = v[COORD_W-1:0];
    endtask

    // Receiver: random stalls, plus one long hold on request
    initial
    begin : receiver
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 18);
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (placements_due.size() == 0)
            begin
                $error("placement result with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = placements_due.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatches++;
                end
                if (pos_x !== want.pos_x)
                begin
                    $error("pos_x: expected %0d, got %0d", want.pos_x, pos_x);
                    mismatches++;
                end
                if (pos_y !== want.pos_y)
                begin
                    $error("pos_y: expected %0d, got %0d", want.pos_y, pos_y);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_directed_tiles();
        set_atlas_size(ATLAS_LIMIT);
        send_tile(1'b1, 0, 5);
        send_tile(1'b0, 7, 0);
        send_tile(1'b0, 0, 0);
        send_tile(1'b1, 4096, 4096);
        send_tile(1'b0, 1, 1);            // no room below a full-height shelf
        send_tile(1'b1, 8191, 1);         // too wide, yet a fresh shelf still opens
        send_tile(1'b0, 1, 8191);
        send_tile(1'b1, 2048, 100);
        send_tile(1'b0, 2048, 100);
        send_tile(1'b0, 1, 50);
        send_tile(1'b0, 4096, 50);
        send_tile(1'b0, 30, 40);
    endtask

    task automatic test_atlas_extremes();
        set_atlas_size(0);
        send_tile(1'b1, 5, 5);
        send_tile(1'b0, 0, 3);
        set_atlas_size(8191);             // clamps to the largest atlas
        send_tile(1'b1, 4096, 4096);
        send_tile(1'b0, 1, 1);
        set_atlas_size(1);
        send_tile(1'b1, 1, 1);
        send_tile(1'b0, 1, 1);
        send_tile(1'b0, 2, 1);
    endtask

    task automatic test_resize_mid_atlas();
        set_atlas_size(1000);
        send_tile(1'b1, 600, 300);
        send_tile(1'b0, 300, 200);
        send_tile(1'b0, 500, 100);
        set_atlas_size(400);              // cursors and edges now lie past the atlas
        send_tile(1'b0, 100, 100);
        send_tile(1'b0, 50, 50);
        set_atlas_size(ATLAS_LIMIT);
        send_tile(1'b0, 100, 100);
        send_tile(1'b0, 3000, 20);
    endtask

    task automatic test_shelf_table_full();
        int k;
        set_atlas_size(ATLAS_LIMIT);
        for (k = 0; k <= SHELF_SLOTS; k++)
            send_tile(k == 0, ATLAS_LIMIT, 1);
        send_tile(1'b0, 1, 1);
        send_tile(1'b0, 1, ATLAS_LIMIT);
    endtask

    task automatic test_backpressure();
        int k;
        set_atlas_size(600);
        hold_req = 1'b1;
        for (k = 0; k < 12; k++)
            send_tile(k == 0, $urandom_range(1, 200), 50);
    endtask

    // Tiles in falling height order, as the packer expects
    task automatic pack_sequence(int side, bit fresh, int count);
        int k, w, h;
        h = $urandom_range(1, side / 3 + 1);
        for (k = 0; k < count; k++)
        begin
            w = $urandom_range(1, side / 2 + 1);
            if ($urandom_range(0, 15) == 0)
                w = $urandom_range(side, side + 8);
            send_tile(fresh && k == 0, w, h);
            h = h - $urandom_range(0, h / 4);
            if (h < 1)
                h = 1;
        end
    endtask

    task automatic test_random_packing();
        int phase, sent, n, side, pick;
        for (phase = 0; phase < 14; phase++)
        begin
            pick = (phase < 2) ? phase : $urandom_range(0, 4);
            case (pick)
                0:       side = 1;
                1:       side = ATLAS_LIMIT;
                2:       side = $urandom_range(2, 64);
                3:       side = $urandom_range(65, 600);
                default: side = $urandom_range(601, ATLAS_LIMIT);
            endcase
            set_atlas_size(side);
            idle_on = (phase < 11) ? ($urandom_range(0, 3) != 0) : 1'b0;
            sent = 0;
            while (sent < 100)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_tile($urandom_range(0, 7) == 0, $urandom_range(0, ATLAS_LIMIT),
                              $urandom_range(0, ATLAS_LIMIT));
                    sent++;
                end
                else
                begin
                    n = $urandom_range(3, 30);
                    // keep the old shelves now and then across a resize
                    pack_sequence(side, (sent == 0) ? bit'($urandom_range(0, 1)) : 1'b1, n);
                    sent += n;
                end
            end
        end
    endtask

    initial
    begin : run
        atlas_edge = ATLAS_RESET;
        clear_rows();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        idle_on = 1'b1;
        test_directed_tiles();
        test_atlas_extremes();
        test_resize_mid_atlas();
        test_shelf_table_full();
        test_backpressure();
        test_random_packing();
        in_valid <= 1'b0;
        while (placements_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/shpk_pkg.sv
hw/rtl/shpk_shelf_mem.sv
hw/rtl/shpk_ctrl.sv
hw/rtl/shelf_packer_first_fit_core.sv
bench/tb.sv
